FILE: rtl/whp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser package
// Types and constants shared by the RIFF/WAVE PCM header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

  localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
  localparam logic [15:0] FORMAT_PCM = 16'h0001;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_AUDIO   = 3'd2;
  localparam logic [2:0] ST_NOWAVE  = 3'd3;
  localparam logic [2:0] ST_NOFMT   = 3'd4;
  localparam logic [2:0] ST_NOPCM   = 3'd5;
  localparam logic [2:0] ST_BADBITS = 3'd6;

  typedef enum logic [7:0] {
    PH_RIFF_LEN  = 8'b0000_0001,
    PH_WAVE      = 8'b0000_0010,
    PH_FMT_HDR   = 8'b0000_0100,
    PH_FMT_BODY  = 8'b0000_1000,
    PH_CHUNK_HDR = 8'b0001_0000,
    PH_SKIP      = 8'b0010_0000,
    PH_AUDIO     = 8'b0100_0000,
    PH_ERROR     = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } whp_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  audio_byte;
    logic [31:0] riff_length;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } whp_result_t;

endpackage

FILE: rtl/whp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser channel interfaces
// Valid/ready channels for file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  audio_byte;
  logic [31:0] riff_length;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] sample_bits;
  logic [31:0] data_length;

  modport source (
    output valid, output status, output audio_byte, output riff_length,
    output channel_count, output sample_rate, output byte_rate,
    output block_align, output sample_bits, output data_length,
    input ready
  );
  modport sink (
    input valid, input status, input audio_byte, input riff_length,
    input channel_count, input sample_rate, input byte_rate,
    input block_align, input sample_bits, input data_length,
    output ready
  );
endinterface

FILE: rtl/whp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser input stage
// Registers one file byte and frees itself when the parser takes it.
// ----------------------------------------------------------------------------
module whp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  whp_in_if.sink            in_if,
  input  logic              advance,
  output whp_pkg::whp_beat_t beat
);
  import whp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_if.in_byte;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;

endmodule

FILE: rtl/whp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser core
// Holds the parse state and works out the result for one file byte.
// ----------------------------------------------------------------------------
module whp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           in_data,
  output whp_pkg::whp_result_t result
);
  import whp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dlen_r, dlen_nxt;
  logic [2:0]  status;
  logic [7:0]  audio;
  logic [31:0] rem_full;

  function automatic logic [31:0] put32(input logic [31:0] old, input logic [7:0] b,
                                        input logic [1:0] pos);
    logic [31:0] r;
    if (pos == 2'd0) begin
      r = {24'd0, b};
    end else begin
      r = old | ({24'd0, b} << {pos, 3'b000});
    end
    return r;
  endfunction

  function automatic logic [15:0] put16(input logic [15:0] old, input logic [7:0] b,
                                        input logic pos);
    logic [15:0] r;
    if (!pos) begin
      r = {8'd0, b};
    end else begin
      r = old | {b, 8'd0};
    end
    return r;
  endfunction

  assign rem_full = {in_data, rem_r[23:0]};

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    riff_nxt  = riff_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    brate_nxt = brate_r;
    align_nxt = align_r;
    bits_nxt  = bits_r;
    dlen_nxt  = dlen_r;
    status    = ST_HEADER;
    audio     = 8'd0;
    unique case (phase_r) inside
      PH_RIFF_LEN: begin
        riff_nxt = put32(riff_r, in_data, idx_r[1:0]);
        idx_nxt  = idx_r + 4'd1;
        if (idx_r == 4'd3) begin
          idx_nxt   = 4'd0;
          phase_nxt = PH_WAVE;
        end
      end
      PH_WAVE: begin
        tag_nxt = put32(tag_r, in_data, idx_r[1:0]);
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd3) begin
          idx_nxt = 4'd0;
          if (tag_nxt != TAG_WAVE) begin
            status    = ST_NOWAVE;
            err_nxt   = ST_NOWAVE;
            phase_nxt = PH_ERROR;
          end else begin
            phase_nxt = PH_FMT_HDR;
          end
        end
      end
      PH_FMT_HDR, PH_CHUNK_HDR: begin
        if (!idx_r[2]) begin
          tag_nxt = put32(tag_r, in_data, idx_r[1:0]);
        end else begin
          rem_nxt = put32(rem_r, in_data, idx_r[1:0]);
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd7) begin
          idx_nxt = 4'd0;
          if (phase_r == PH_FMT_HDR) begin
            if (tag_r != TAG_FMT) begin
              status    = ST_NOFMT;
              err_nxt   = ST_NOFMT;
              phase_nxt = PH_ERROR;
            end else begin
              phase_nxt = PH_FMT_BODY;
            end
          end else if (tag_r == TAG_DATA) begin
            dlen_nxt  = rem_full;
            status    = ST_DONE;
            phase_nxt = PH_AUDIO;
          end else if (rem_full != 32'd0) begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_FMT_BODY: begin
        case (idx_r) inside
          [4'd0:4'd1]:   tag_nxt   = put32(tag_r, in_data, {1'b0, idx_r[0]});
          [4'd2:4'd3]:   chan_nxt  = put16(chan_r, in_data, idx_r[0]);
          [4'd4:4'd7]:   rate_nxt  = put32(rate_r, in_data, idx_r[1:0]);
          [4'd8:4'd11]:  brate_nxt = put32(brate_r, in_data, idx_r[1:0]);
          [4'd12:4'd13]: align_nxt = put16(align_r, in_data, idx_r[0]);
          default:       bits_nxt  = put16(bits_r, in_data, idx_r[0]);
        endcase
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd1 && {in_data, tag_r[7:0]} != FORMAT_PCM) begin
          status    = ST_NOPCM;
          err_nxt   = ST_NOPCM;
          phase_nxt = PH_ERROR;
        end else if (idx_r == 4'd15) begin
          idx_nxt = 4'd0;
          if (bits_r[2:0] != 3'd0) begin
            status    = ST_BADBITS;
            err_nxt   = ST_BADBITS;
            phase_nxt = PH_ERROR;
          end else if (rem_r > FMT_BODY_LEN) begin
            rem_nxt   = rem_r - FMT_BODY_LEN;
            phase_nxt = PH_SKIP;
          end else begin
            rem_nxt   = 32'd0;
            phase_nxt = PH_CHUNK_HDR;
          end
        end
      end
      PH_SKIP: begin
        if (rem_r != 32'd0) begin
          rem_nxt = rem_r - 32'd1;
        end
        if (rem_r <= 32'd1) begin
          idx_nxt   = 4'd0;
          phase_nxt = PH_CHUNK_HDR;
        end
      end
      PH_AUDIO: begin
        status = ST_AUDIO;
        audio  = in_data;
      end
      PH_ERROR: begin
        status = err_r;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF_LEN;
      idx_r   <= 4'd0;
      tag_r   <= 32'd0;
      rem_r   <= 32'd0;
      err_r   <= 3'd0;
      riff_r  <= 32'd0;
      chan_r  <= 16'd0;
      rate_r  <= 32'd0;
      brate_r <= 32'd0;
      align_r <= 16'd0;
      bits_r  <= 16'd0;
      dlen_r  <= 32'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
      err_r   <= err_nxt;
      riff_r  <= riff_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      brate_r <= brate_nxt;
      align_r <= align_nxt;
      bits_r  <= bits_nxt;
      dlen_r  <= dlen_nxt;
    end
  end

  assign result.status        = status;
  assign result.audio_byte    = audio;
  assign result.riff_length   = riff_nxt;
  assign result.channel_count = chan_nxt;
  assign result.sample_rate   = rate_nxt;
  assign result.byte_rate     = brate_nxt;
  assign result.block_align   = align_nxt;
  assign result.sample_bits   = bits_nxt;
  assign result.data_length   = dlen_nxt;

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR) |=> (phase_r == PH_ERROR) && $stable(err_r))
    else $error("Parser left the error phase or changed its error code.");

  a_audio_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_AUDIO) |=> (phase_r == PH_AUDIO))
    else $error("Parser left the audio phase.");

  a_short_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RIFF_LEN || phase_r == PH_WAVE) |-> (idx_r < 4'd4))
    else $error("Byte index ran past a four-byte field.");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (rem_r != 32'd0))
    else $error("Skip phase entered with nothing left to skip.");

endmodule

FILE: rtl/wav_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser
// Parses a RIFF/WAVE PCM header one byte per word and passes audio bytes on.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// in_if    sink       in_byte: next file byte after the RIFF tag
// out_if   source     status, audio_byte and the captured header fields
//
// Every input word gives exactly one output word, which passes through the input
// register and then the result register before it appears on the output.
// One word per cycle is sustained while the output is ready; the parse state updates once per word taken.
// Reset is synchronous and active low; it returns the parser to the RIFF length.
// A stalled output holds its word; the input register still takes one more word.
// ----------------------------------------------------------------------------
module wav_header_parser (
  input  logic     clk,
  input  logic     rst_n,
  whp_in_if.sink   in_if,
  whp_out_if.source out_if
);
  import whp_pkg::*;

  whp_beat_t   beat;
  whp_result_t result;
  whp_result_t res_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        advance;
  logic        fire;

  assign advance = !out_valid_r || out_if.ready;
  assign fire    = beat.valid && advance;

  whp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .advance (advance),
    .beat    (beat)
  );

  whp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_data (beat.data),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = res_r.status;
  assign out_if.audio_byte    = res_r.audio_byte;
  assign out_if.riff_length   = res_r.riff_length;
  assign out_if.channel_count = res_r.channel_count;
  assign out_if.sample_rate   = res_r.sample_rate;
  assign out_if.byte_rate     = res_r.byte_rate;
  assign out_if.block_align   = res_r.block_align;
  assign out_if.sample_bits   = res_r.sample_bits;
  assign out_if.data_length   = res_r.data_length;

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("A parsed word did not reach the output register.");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Feeds a generated RIFF/WAVE byte stream through the parser with random
// gaps and output stalls. A byte-level parse model predicts every output word,
// and each word is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import whp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_WAVE,
    FAULT_FMT,
    FAULT_PCM,
    FAULT_BITS
  } fault_t;

  logic clk;
  logic rst_n;

  whp_in_if  in_if();
  whp_out_if out_if();

  wav_header_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic [7:0]  file_bytes[$];
  whp_result_t parse_results_due[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic        in_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;

  phase_t      parse_ph;
  logic [31:0] byte_idx;
  logic [31:0] bit_pos;
  logic [31:0] tag_word;
  logic [31:0] bytes_left;
  logic [2:0]  sticky_err;
  logic [31:0] fields [7];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic take_byte(inout logic [31:0] dst, input logic [7:0] b,
                                     input int unsigned nbytes);
    if (bit_pos == 0) begin
      dst = {24'd0, b};
    end else begin
      dst = dst | ({24'd0, b} << bit_pos);
    end
    bit_pos = bit_pos + 8;
    if (bit_pos >= 8 * nbytes) begin
      bit_pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] raise_error(input logic [2:0] code);
    sticky_err = code;
    parse_ph = PH_ERROR;
    return code;
  endfunction

  function automatic whp_result_t parse_byte(input logic [7:0] b);
    whp_result_t r;
    logic [2:0]  st;
    logic [7:0]  aud;
    logic [31:0] k;
    st = ST_HEADER;
    aud = 8'd0;
    case (parse_ph)
      PH_RIFF_LEN: begin
        if (take_byte(fields[0], b, 4)) parse_ph = PH_WAVE;
      end
      PH_WAVE: begin
        if (take_byte(tag_word, b, 4)) begin
          if (tag_word != TAG_WAVE) begin
            st = raise_error(ST_NOWAVE);
          end else begin
            parse_ph = PH_FMT_HDR;
            byte_idx = 0;
          end
        end
      end
      PH_FMT_HDR, PH_CHUNK_HDR: begin
        if (byte_idx < 4) void'(take_byte(tag_word, b, 4));
        else void'(take_byte(bytes_left, b, 4));
        byte_idx = byte_idx + 1;
        if (byte_idx >= 8) begin
          byte_idx = 0;
          bit_pos = 0;
          if (parse_ph == PH_FMT_HDR) begin
            if (tag_word != TAG_FMT) st = raise_error(ST_NOFMT);
            else parse_ph = PH_FMT_BODY;
          end else if (tag_word == TAG_DATA) begin
            fields[6] = bytes_left;
            st = ST_DONE;
            parse_ph = PH_AUDIO;
          end else if (bytes_left != 0) begin
            parse_ph = PH_SKIP;
          end
        end
      end
      PH_FMT_BODY: begin
        k = byte_idx;
        if (k < 2) void'(take_byte(tag_word, b, 2));
        else if (k < 4) void'(take_byte(fields[1], b, 2));
        else if (k < 8) void'(take_byte(fields[2], b, 4));
        else if (k < 12) void'(take_byte(fields[3], b, 4));
        else if (k < 14) void'(take_byte(fields[4], b, 2));
        else void'(take_byte(fields[5], b, 2));
        byte_idx = k + 1;
        if (byte_idx == 2 && tag_word != {16'd0, FORMAT_PCM}) begin
          st = raise_error(ST_NOPCM);
        end else if (byte_idx >= 16) begin
          byte_idx = 0;
          bit_pos = 0;
          if (fields[5][2:0] != 3'd0) begin
            st = raise_error(ST_BADBITS);
          end else begin
            bytes_left = (bytes_left > FMT_BODY_LEN) ? bytes_left - FMT_BODY_LEN : 32'd0;
            parse_ph = (bytes_left != 0) ? PH_SKIP : PH_CHUNK_HDR;
          end
        end
      end
      PH_SKIP: begin
        if (bytes_left != 0) bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          parse_ph = PH_CHUNK_HDR;
          byte_idx = 0;
          bit_pos = 0;
        end
      end
      PH_AUDIO: begin
        st = ST_AUDIO;
        aud = b;
      end
      default: begin
        st = sticky_err;
      end
    endcase
    r.status        = st;
    r.audio_byte    = aud;
    r.riff_length   = fields[0];
    r.channel_count = fields[1][15:0];
    r.sample_rate   = fields[2];
    r.byte_rate     = fields[3];
    r.block_align   = fields[4][15:0];
    r.sample_bits   = fields[5][15:0];
    r.data_length   = fields[6];
    return r;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] spoil_tag(input logic [31:0] tag);
    logic [31:0] flip;
    flip = {24'd0, 8'($urandom_range(1, 255))};
    return tag ^ (flip << (8 * $urandom_range(0, 3)));
  endfunction

  task automatic put_le(input logic [31:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic flag(input string msg);
    error_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      flag($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
    end
  endtask

  always @(negedge clk) begin : driver
    if (rst_n) begin
      if (!in_if.valid || in_taken) begin
        if (in_gap != 0) begin
          in_if.valid <= 1'b0;
          in_gap = in_gap - 1;
        end else if (file_bytes.size() != 0) begin
          in_if.valid <= 1'b1;
          in_if.in_byte <= file_bytes.pop_front();
          in_gap = pick_gap(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (out_stall != 0) begin
        out_if.ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin : monitor
    whp_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (parse_results_due.size() == 0) begin
          flag($sformatf("unexpected word: status %0h audio %0h",
                         out_if.status, out_if.audio_byte));
        end else begin
          want = parse_results_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_if.status));
          check_field("audio_byte", 32'(want.audio_byte), 32'(out_if.audio_byte));
          check_field("riff_length", want.riff_length, out_if.riff_length);
          check_field("channel_count", 32'(want.channel_count),
                      32'(out_if.channel_count));
          check_field("sample_rate", want.sample_rate, out_if.sample_rate);
          check_field("byte_rate", want.byte_rate, out_if.byte_rate);
          check_field("block_align", 32'(want.block_align), 32'(out_if.block_align));
          check_field("sample_bits", 32'(want.sample_bits), 32'(out_if.sample_bits));
          check_field("data_length", want.data_length, out_if.data_length);
        end
      end
      if (in_if.valid && in_if.ready) begin
        parse_results_due.push_back(parse_byte(in_if.in_byte));
      end
    end
    in_taken <= rst_n && in_if.valid && in_if.ready;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    fault_t      fault;
    logic [31:0] v;
    int unsigned fmt_len;
    int unsigned len;
    int unsigned n_chunks;

    parse_ph = PH_RIFF_LEN;
    byte_idx = 0;
    bit_pos = 0;
    tag_word = 0;
    bytes_left = 0;
    sticky_err = 3'd0;
    for (int i = 0; i < 7; i++) fields[i] = 32'd0;

    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'd0;
    out_if.ready = 1'b0;

    // Most runs parse a well-formed header; some break it at one point.
    fault = FAULT_NONE;
    if ($urandom_range(0, 11) < 4) fault = fault_t'($urandom_range(1, 4));

    put_le(pick_value(), 4);
    put_le((fault == FAULT_WAVE) ? spoil_tag(TAG_WAVE) : TAG_WAVE, 4);

    put_le((fault == FAULT_FMT) ? spoil_tag(TAG_FMT) : TAG_FMT, 4);
    case ($urandom_range(0, 3))
      0: fmt_len = 16;
      1: fmt_len = $urandom_range(0, 15);
      2: fmt_len = 17;
      default: fmt_len = $urandom_range(18, 40);
    endcase
    put_le(fmt_len, 4);

    v = pick_value();
    if (fault == FAULT_PCM) begin
      if (v[15:0] == FORMAT_PCM) v = 32'd0;
    end else begin
      v = {16'd0, FORMAT_PCM};
    end
    put_le(v, 2);
    put_le(pick_value(), 2);
    put_le(pick_value(), 4);
    put_le(pick_value(), 4);
    put_le(pick_value(), 2);
    v = pick_value();
    v[2:0] = (fault == FAULT_BITS) ? 3'($urandom_range(1, 7)) : 3'd0;
    put_le(v, 2);
    for (int unsigned i = 16; i < fmt_len; i++) file_bytes.push_back(8'($urandom));

    // An empty chunk, a second fmt tag seen as an unknown chunk, a one-byte chunk.
    v = $urandom;
    if (v == TAG_DATA) v = ~v;
    put_le(v, 4);
    put_le(32'd0, 4);
    put_le(TAG_FMT, 4);
    put_le(32'd3, 4);
    put_le($urandom, 3);
    put_le($urandom, 4);
    put_le(32'd1, 4);
    file_bytes.push_back(8'($urandom));

    n_chunks = $urandom_range(2, 8);
    for (int unsigned c = 0; c < n_chunks; c++) begin
      v = $urandom;
      if (v == TAG_DATA) v = ~v;
      len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
      put_le(v, 4);
      put_le(len, 4);
      for (int unsigned i = 0; i < len; i++) file_bytes.push_back(8'($urandom));
    end

    put_le(TAG_DATA, 4);
    put_le(pick_value(), 4);
    put_le(32'hAA55_FF00, 4);
    while (file_bytes.size() < 600) file_bytes.push_back(8'($urandom));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (file_bytes.size() != 0 || in_if.valid) @(posedge clk);
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/whp_pkg.sv
rtl/whp_ifs.sv
rtl/whp_in_stage.sv
rtl/whp_parser.sv
rtl/wav_header_parser.sv
tb/tb.sv
